// ----- sv/qrrs_pkg.sv -----
`timescale 1ns / 1ps

package qrrs_pkg;

  // Fixed widths of the request and result fields.
  localparam int FIELD_W = 16;
  localparam int ROOT_W  = 40;

  // Classification of one request.
  typedef enum logic [1:0] {
    OUT_NONE   = 2'd0,
    OUT_DOUBLE = 2'd1,
    OUT_TWO    = 2'd2,
    OUT_AZERO  = 2'd3
  } outcome_e;

  typedef struct packed {
    logic signed [FIELD_W-1:0] coef_a;
    logic signed [FIELD_W-1:0] coef_b;
    logic signed [FIELD_W-1:0] coef_c;
  } qrrs_req_t;

  typedef struct packed {
    outcome_e                 outcome;
    logic signed [ROOT_W-1:0] root_plus;
    logic signed [ROOT_W-1:0] root_minus;
  } qrrs_res_t;

  // Direction of the fraction left over by an inexact square root.
  typedef struct packed {
    logic nz;
    logic neg;
  } qrrs_eps_t;

endpackage

// ----- sv/qrrs_front.sv -----
`timescale 1ns / 1ps

module qrrs_front import qrrs_pkg::*; #(
  parameter int CW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  qrrs_req_t         req_i,
  output logic              valid_o,
  output logic [2*CW:0]     disc_o,
  output outcome_e          outcome_o,
  output logic signed [CW-1:0] a_o,
  output logic signed [CW-1:0] b_o
);

  localparam int DW = 2 * CW + 2;

  logic              v0_q, v1_q, v2_q;
  logic signed [CW-1:0] a0_q, b0_q, c0_q, a1_q, b1_q, a2_q, b2_q;
  logic signed [2*CW-1:0] bb_q, ac_q, bb_d, ac_d;
  logic signed [DW-1:0]   disc_d;
  logic [DW-1:0]          disc_q;
  logic [31:0]            ea, eb, ec;
  outcome_e               out_d, out_q;

  // Upper bits beyond the coefficient width are dropped, missing ones read as zero.
  assign ea = 32'($unsigned(req_i.coef_a));
  assign eb = 32'($unsigned(req_i.coef_b));
  assign ec = 32'($unsigned(req_i.coef_c));

  // Stage one: capture the coefficients.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a0_q <= ea[CW-1:0];
    b0_q <= eb[CW-1:0];
    c0_q <= ec[CW-1:0];
  end

  // Stage two: the two products.
  assign bb_d = b0_q * b0_q;
  assign ac_d = a0_q * c0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bb_q <= bb_d;
    ac_q <= ac_d;
    a1_q <= a0_q;
    b1_q <= b0_q;
  end

  // Stage three: the discriminant and the classification.
  assign disc_d = DW'(bb_q) - (DW'(ac_q) <<< 2);

  always_comb begin
    if (a1_q == '0) begin
      out_d = OUT_AZERO;
    end else if (disc_d[DW-1]) begin
      out_d = OUT_NONE;
    end else if (disc_d == '0) begin
      out_d = OUT_DOUBLE;
    end else begin
      out_d = OUT_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    disc_q <= disc_d;
    out_q  <= out_d;
    a2_q   <= a1_q;
    b2_q   <= b1_q;
  end

  assign valid_o   = v2_q;
  assign disc_o    = disc_q[2*CW:0];
  assign outcome_o = out_q;
  assign a_o       = a2_q;
  assign b_o       = b2_q;

endmodule

// ----- sv/qrrs_sqrt.sv -----
`timescale 1ns / 1ps

module qrrs_sqrt #(
  parameter int NB = 49,
  parameter int SW = 34
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*NB-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [NB-1:0]   root_o,
  output logic            exact_o,
  output logic [SW-1:0]   side_o
);

  localparam int RW = NB + 2;

  logic            v_q    [NB+1];
  logic [2*NB-1:0] rad_q  [NB+1];
  logic [RW-1:0]   rem_q  [NB+1];
  logic [NB-1:0]   root_q [NB+1];
  logic [SW-1:0]   side_q [NB+1];

  // Entry of the pipeline is the incoming request itself.
  always_comb begin
    v_q[0]    = valid_i;
    rad_q[0]  = rad_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
    side_q[0] = side_i;
  end

  // One root digit per stage, taken from the next pair of radicand bits.
  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic [RW+1:0] rem_sh, trial, rem_sub;
    logic          ge;

    always_comb begin
      rem_sh  = {rem_q[i], rad_q[i][2*NB-1 -: 2]};
      trial   = {2'b00, root_q[i], 2'b01};
      ge      = rem_sh >= trial;
      rem_sub = rem_sh - trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[i+1]  <= rad_q[i] << 2;
      rem_q[i+1]  <= ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
      root_q[i+1] <= {root_q[i][NB-2:0], ge};
      side_q[i+1] <= side_q[i];
    end
  end

  assign valid_o = v_q[NB];
  assign root_o  = root_q[NB];
  assign exact_o = rem_q[NB] == '0;
  assign side_o  = side_q[NB];

endmodule

// ----- sv/qrrs_div.sv -----
`timescale 1ns / 1ps

module qrrs_div import qrrs_pkg::*; #(
  parameter int KW = 35,
  parameter int MW = 17,
  parameter int SW = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [KW-1:0] num_i,
  input  qrrs_eps_t            eps_i,
  input  logic [MW-1:0]        den_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic [KW-2:0]        quo_o,
  output logic                 neg_o,
  output logic [SW-1:0]        side_o
);

  localparam int DV = KW - 1;

  logic          v_q   [DV+1];
  logic [DV-1:0] dq_q  [DV+1];
  logic [MW-1:0] rem_q [DV+1];
  logic [MW-1:0] den_q [DV+1];
  logic          neg_q [DV+1];
  logic [SW-1:0] side_q[DV+1];

  logic          num_neg, num_zero, dec, neg_d;
  logic [KW-1:0] mag;
  logic [DV-1:0] dvd_d;

  // A leftover fraction pointing toward zero lowers the magnitude by one
  // before the floor division.
  always_comb begin
    num_neg  = num_i[KW-1];
    num_zero = num_i == '0;
    mag      = num_neg ? KW'(0) - KW'(num_i) : KW'(num_i);
    dec      = eps_i.nz && !num_zero && (num_neg != eps_i.neg);
    dvd_d    = mag[DV-1:0] - DV'(dec);
    neg_d    = num_neg || (num_zero && eps_i.nz && eps_i.neg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q[0]   <= dvd_d;
    rem_q[0]  <= '0;
    den_q[0]  <= den_i;
    neg_q[0]  <= neg_d;
    side_q[0] <= side_i;
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 0; j < DV; j++) begin : g_stage
    logic [MW:0] r2, r2_sub;
    logic        ge;

    always_comb begin
      r2     = {rem_q[j], dq_q[j][DV-1]};
      ge     = r2 >= {1'b0, den_q[j]};
      r2_sub = r2 - {1'b0, den_q[j]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1]  <= ge ? r2_sub[MW-1:0] : r2[MW-1:0];
      dq_q[j+1]   <= {dq_q[j][DV-2:0], ge};
      den_q[j+1]  <= den_q[j];
      neg_q[j+1]  <= neg_q[j];
      side_q[j+1] <= side_q[j];
    end
  end

  assign valid_o = v_q[DV];
  assign quo_o   = dq_q[DV];
  assign neg_o   = neg_q[DV];
  assign side_o  = side_q[DV];

endmodule

// ----- sv/quadratic_real_root_solver.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Signals                  Handshake
// request   in         req_i (a, b, c)          taken when start_i is high and busy_o low
// result    out        res_o (outcome, roots)   valid for the one cycle that done_o is high
//
// A request may be taken in every cycle; busy_o stays low.
// Results pass through the front stages, the square root pipeline (one digit per
// stage), the numerator register, the restoring dividers and the output register.
// Reset clears only the valid bits of the pipeline; requests in flight are dropped.
// The receiver cannot stall, so results leave strictly in request order.
module quadratic_real_root_solver import qrrs_pkg::*; #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  qrrs_req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output qrrs_res_t res_o
);

  localparam int CW  = COEF_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int NB  = CW + FB + 1;
  localparam int KW  = CW + FB + 3;
  localparam int MW  = CW + 1;
  localparam int DV  = KW - 1;
  localparam int SW  = 2 + 2 * CW;
  localparam int EW  = (DV > ROOT_W + 1) ? DV : ROOT_W + 1;
  localparam logic [EW-1:0] POS_MAX = EW'((64'd1 << (ROOT_W - 1)) - 64'd1);
  localparam logic [EW-1:0] NEG_LIM = EW'(64'd1 << (ROOT_W - 1));

  logic                 fr_valid;
  logic [2*CW:0]        fr_disc;
  outcome_e             fr_out;
  logic signed [CW-1:0] fr_a, fr_b;

  logic                 sq_valid, sq_exact;
  logic [NB-1:0]        sq_root;
  logic [SW-1:0]        sq_side;
  logic [2*NB-1:0]      rad;

  logic signed [CW-1:0] pa, pb;
  outcome_e             pout;
  logic signed [KW-1:0] kbn, kp, km;
  logic [CW:0]          abs_a;

  logic                 pv_q;
  logic signed [KW-1:0] np_q, nm_q;
  qrrs_eps_t            ep_q, em_q;
  logic [MW-1:0]        den_q;
  outcome_e             pout_q;

  logic                 dp_valid, dm_valid, dp_neg, dm_neg;
  logic [DV-1:0]        dp_quo, dm_quo;
  logic [1:0]           dp_side, dm_side;
  outcome_e             fin_out;

  logic                 done_q;
  qrrs_res_t            res_q;
  logic                 keep;

  assign busy_o = 1'b0;

  qrrs_front #(.CW(CW)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i && !busy_o),
    .req_i     (req_i),
    .valid_o   (fr_valid),
    .disc_o    (fr_disc),
    .outcome_o (fr_out),
    .a_o       (fr_a),
    .b_o       (fr_b)
  );

  // Radicand is the discriminant scaled by four to the fraction bits.
  assign rad = (2*NB)'(fr_disc) << (2 * FB);

  qrrs_sqrt #(.NB(NB), .SW(SW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .rad_i   (rad),
    .side_i  ({fr_out, fr_a, fr_b}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .exact_o (sq_exact),
    .side_o  (sq_side)
  );

  // Numerators -b*2^F +/- root, turned so that the divisor is positive.
  always_comb begin
    pout  = outcome_e'(sq_side[SW-1 -: 2]);
    pa    = sq_side[2*CW-1:CW];
    pb    = sq_side[CW-1:0];
    kbn   = KW'(0) - (KW'(pb) <<< FB);
    kp    = kbn + KW'(sq_root);
    km    = kbn - KW'(sq_root);
    abs_a = pa[CW-1] ? (CW+1)'(0) - (CW+1)'(pa) : (CW+1)'(pa);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    np_q   <= pa[CW-1] ? KW'(0) - kp : kp;
    nm_q   <= pa[CW-1] ? KW'(0) - km : km;
    ep_q   <= '{nz: !sq_exact, neg: pa[CW-1]};
    em_q   <= '{nz: !sq_exact, neg: !pa[CW-1]};
    den_q  <= {abs_a[CW-1:0], 1'b0};
    pout_q <= pout;
  end

  qrrs_div #(.KW(KW), .MW(MW), .SW(2)) u_div_plus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pv_q),
    .num_i   (np_q),
    .eps_i   (ep_q),
    .den_i   (den_q),
    .side_i  (pout_q),
    .valid_o (dp_valid),
    .quo_o   (dp_quo),
    .neg_o   (dp_neg),
    .side_o  (dp_side)
  );

  qrrs_div #(.KW(KW), .MW(MW), .SW(2)) u_div_minus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pv_q),
    .num_i   (nm_q),
    .eps_i   (em_q),
    .den_i   (den_q),
    .side_i  (pout_q),
    .valid_o (dm_valid),
    .quo_o   (dm_quo),
    .neg_o   (dm_neg),
    .side_o  (dm_side)
  );

  // Apply the sign and clamp to the forty-bit result range.
  function automatic logic [ROOT_W-1:0] sat_root(logic [DV-1:0] q, logic neg);
    logic [EW-1:0] qx;
    logic [EW-1:0] nq;
    qx = EW'(q);
    nq = EW'(0) - qx;
    if (neg) begin
      sat_root = (qx > NEG_LIM) ? NEG_LIM[ROOT_W-1:0] : nq[ROOT_W-1:0];
    end else begin
      sat_root = (qx > POS_MAX) ? POS_MAX[ROOT_W-1:0] : qx[ROOT_W-1:0];
    end
  endfunction

  assign fin_out = outcome_e'(dp_side);
  assign keep    = (fin_out == OUT_DOUBLE) || (fin_out == OUT_TWO);

  // Output register; roots read zero unless real roots exist.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.outcome    <= fin_out;
    res_q.root_plus  <= keep ? sat_root(dp_quo, dp_neg) : '0;
    res_q.root_minus <= keep ? sat_root(dm_quo, dm_neg) : '0;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // The two divider lanes stay in lock step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_valid == dm_valid) && (!dp_valid || dp_side == dm_side))
    else $error("divider lanes out of step");

  // Without real roots both root fields are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.outcome == OUT_NONE || res_o.outcome == OUT_AZERO)
      |-> (res_o.root_plus == '0) && (res_o.root_minus == '0))
    else $error("roots not cleared");

  // A double root gives equal roots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.outcome == OUT_DOUBLE |-> res_o.root_plus == res_o.root_minus)
    else $error("double root mismatch");

endmodule
